>>> hw/rtl/modular_arithmetic_unit_assert.svh
// assertion macros for the modular arithmetic unit
// expects i_clk and i_rst_n in the scope of the including module
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MAU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mau assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define MAU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mau assertion failed: next-cycle implication");

`endif

>>> hw/rtl/mau_pkg.sv
// shared types and constants of the modular arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package mau_pkg;

    localparam int unsigned RES_W  = 30;
    localparam int unsigned WIDE_W = 64;
    localparam int unsigned UV_W   = 32;

    localparam logic [RES_W-1:0] MOD_RESET = 30'd1000000007;

    typedef logic [RES_W-1:0] t_res;

    typedef enum logic [2:0] {
        FN_REDUCE = 3'd0,
        FN_ADD    = 3'd1,
        FN_SUB    = 3'd2,
        FN_MUL    = 3'd3,
        FN_DIV    = 3'd4,
        FN_NEG    = 3'd5,
        FN_INV    = 3'd6,
        FN_POW    = 3'd7
    } t_func;

    // one shift-subtract step: res = (2*acc + add) reduced by div
    typedef struct packed {
        t_res acc;
        t_res add;
        t_res div;
    } t_step_req;

    typedef struct packed {
        t_res res;
        logic ge;
    } t_step_rsp;

    typedef struct packed {
        logic fin;
        t_res value;
    } t_fin;

endpackage

>>> hw/rtl/modular_arithmetic_unit.sv
// top level of the modular arithmetic unit: modulus register, result register,
// sequencer and shared step unit; depends on mau_pkg, mau_step and mau_seq
`timescale 1ns / 1ps

//  channel   direction  transfer when               payload
//  command   in         start && !busy              i_func, i_operand_a, i_operand_b, i_wide_value
//  result    out        o_valid (one cycle)         o_residue
//  config    in         i_cfg_valid && o_cfg_ready  i_cfg_data (modulus)
//
// every item runs on one shift-subtract step unit, one bit per cycle, in these steps:
//   operand reduce per residue operand, then modular multiply for mul, euclid rounds
//   for inverse, both for div; reduce shifts in the wide magnitude, add/sub/negate finish
//   directly; power skips leading zeros, then per later bit squares and on a one multiplies
// reset is synchronous active low and loads the modulus with 1000000007
// no stall on results; config waits for idle and no start; modulus below two: zero result

module modular_arithmetic_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_func,
    input  logic [mau_pkg::RES_W-1:0]          i_operand_a,
    input  logic [mau_pkg::RES_W-1:0]          i_operand_b,
    input  logic signed [mau_pkg::WIDE_W-1:0]  i_wide_value,
    output logic                               o_valid,
    output logic [mau_pkg::RES_W-1:0]          o_residue,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mau_pkg::RES_W-1:0]          i_cfg_data
);
    import mau_pkg::*;

    t_res       r_modulus;
    logic       r_valid;
    t_res       r_residue;
    logic       w_busy;
    t_fin       w_fin;
    t_step_req  w_step_req;
    t_step_rsp  w_step_rsp;

    // config only lands between items, never beside a command transfer
    assign o_cfg_ready = ~w_busy & ~start;
    assign busy        = w_busy;
    assign o_valid     = r_valid;
    assign o_residue   = r_residue;

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_modulus <= i_cfg_data;
        end
    end

    // result register, strobe lasts exactly one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_fin.fin;
        end
        if (w_fin.fin) begin
            r_residue <= w_fin.value;
        end
    end

    // sequencer steering the shared unit
    mau_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_func       (t_func'(i_func)),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .i_wide_value (i_wide_value),
        .i_modulus    (r_modulus),
        .o_busy       (w_busy),
        .o_fin        (w_fin),
        .o_step_req   (w_step_req),
        .i_step_rsp   (w_step_rsp)
    );

    // shared double-add-reduce step
    mau_step u_step (
        .i_req (w_step_req),
        .o_rsp (w_step_rsp)
    );

endmodule

>>> hw/rtl/mau_step.sv
// shared shift-subtract step unit: doubles, adds and reduces by up to two divisors
// depends on mau_pkg
`timescale 1ns / 1ps

module mau_step (
    input  mau_pkg::t_step_req i_req,
    output mau_pkg::t_step_rsp o_rsp
);
    import mau_pkg::*;

    logic [32:0] w_t;
    logic [32:0] w_s1;
    logic [32:0] w_s2;

    assign w_t  = {2'b00, i_req.acc, 1'b0} + {3'b000, i_req.add};
    assign w_s1 = w_t - {3'b000, i_req.div};
    assign w_s2 = w_t - {2'b00, i_req.div, 1'b0};

    always_comb begin
        o_rsp.ge = ~w_s1[32];
        if (!w_s2[32]) begin
            o_rsp.res = w_s2[RES_W-1:0];
        end else if (!w_s1[32]) begin
            o_rsp.res = w_s1[RES_W-1:0];
        end else begin
            o_rsp.res = w_t[RES_W-1:0];
        end
    end

endmodule

>>> hw/rtl/mau_seq.sv
// sequencer of the modular arithmetic unit: operand reduction, modular multiply,
// extended euclid and square-and-multiply, all through the shared step unit
// depends on mau_pkg and modular_arithmetic_unit_assert.svh
`timescale 1ns / 1ps
`include "modular_arithmetic_unit_assert.svh"

module mau_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  mau_pkg::t_func              i_func,
    input  logic [mau_pkg::RES_W-1:0]   i_operand_a,
    input  logic [mau_pkg::RES_W-1:0]   i_operand_b,
    input  logic signed [mau_pkg::WIDE_W-1:0] i_wide_value,
    input  logic [mau_pkg::RES_W-1:0]   i_modulus,
    output logic                        o_busy,
    output mau_pkg::t_fin               o_fin,
    output mau_pkg::t_step_req          o_step_req,
    input  mau_pkg::t_step_rsp          i_step_rsp
);
    import mau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_RED_W,
        S_RED_FIN,
        S_OP_GO,
        S_MUL,
        S_FIN_ACC,
        S_EUC_CHK,
        S_EUC_DIV,
        S_EUC_UPD,
        S_EUC_FIN,
        S_PWR_SCAN,
        S_PWR_SQ,
        S_PWR_ML
    } t_state;

    localparam logic [4:0] MCNT_LAST = 5'(RES_W - 1);
    localparam logic [6:0] WCNT_LAST = 7'(WIDE_W - 1);
    localparam logic [6:0] PCNT_INIT = 7'(WIDE_W);

    t_state             r_state;
    t_state             r_ret;
    t_func              r_func;
    t_res               r_a;
    t_res               r_b;
    logic [WIDE_W-1:0]  r_w;
    logic               r_neg;
    t_res               r_acc;
    t_res               r_mx;
    t_res               r_my;
    logic [4:0]         r_mcnt;
    logic [6:0]         r_cnt;
    t_res               r_ea;
    t_res               r_eb;
    logic signed [UV_W-1:0] r_eu;
    logic signed [UV_W-1:0] r_ev;
    logic signed [UV_W-1:0] r_tv;
    logic signed [UV_W-1:0] n_tv;
    t_res               r_pr;
    logic               r_started;

    logic [WIDE_W-1:0]  w_mag;
    logic [RES_W:0]     w_sum;
    t_res               w_sum_r;
    t_res               w_diff;
    t_res               w_neg_r;
    t_res               w_red;
    logic [UV_W-1:0]    w_u_mag;
    logic [UV_W-1:0]    w_u_red;
    t_res               w_inv;
    logic               w_pow_le0;
    logic               w_needs_b;
    logic               w_step_act;

    assign o_busy = (r_state != S_IDLE);

    // step unit operand selection
    always_comb begin
        o_step_req.acc = r_acc;
        o_step_req.add = '0;
        o_step_req.div = i_modulus;
        case (r_state)
            S_RED_A:   o_step_req.add = {{(RES_W-1){1'b0}}, r_a[RES_W-1]};
            S_RED_B:   o_step_req.add = {{(RES_W-1){1'b0}}, r_b[RES_W-1]};
            S_RED_W:   o_step_req.add = {{(RES_W-1){1'b0}}, r_w[WIDE_W-1]};
            S_MUL:     o_step_req.add = r_my[RES_W-1] ? r_mx : '0;
            S_EUC_DIV: begin
                o_step_req.add = {{(RES_W-1){1'b0}}, r_ea[RES_W-1]};
                o_step_req.div = r_eb;
            end
            default:   o_step_req.add = '0;
        endcase
    end

    assign w_step_act = (r_state == S_RED_A) || (r_state == S_RED_B) ||
                        (r_state == S_RED_W) || (r_state == S_MUL) ||
                        (r_state == S_EUC_DIV);

    // quotient times v, built msb first alongside the division
    assign n_tv = {r_tv[UV_W-2:0], 1'b0} + (i_step_rsp.ge ? r_ev : '0);

    assign w_mag     = i_wide_value[WIDE_W-1] ? (64'd0 - i_wide_value) : i_wide_value;
    assign w_sum     = {1'b0, r_a} + {1'b0, r_b};
    assign w_sum_r   = (w_sum >= {1'b0, i_modulus}) ? RES_W'(w_sum - {1'b0, i_modulus})
                                                    : w_sum[RES_W-1:0];
    assign w_diff    = (r_a >= r_b) ? (r_a - r_b) : (r_a + (i_modulus - r_b));
    assign w_neg_r   = (r_a == '0) ? '0 : (i_modulus - r_a);
    assign w_red     = (!r_neg || r_acc == '0) ? r_acc : (i_modulus - r_acc);
    assign w_u_mag   = r_eu[UV_W-1] ? (32'd0 - r_eu) : r_eu;
    assign w_u_red   = (w_u_mag >= {2'b00, i_modulus}) ? (w_u_mag - {2'b00, i_modulus})
                                                        : w_u_mag;
    assign w_inv     = (!r_eu[UV_W-1] || w_u_red == '0) ? w_u_red[RES_W-1:0]
                                                         : (i_modulus - w_u_red[RES_W-1:0]);
    assign w_pow_le0 = r_w[WIDE_W-1] || (r_w == '0);
    assign w_needs_b = (r_func == FN_ADD) || (r_func == FN_SUB) ||
                       (r_func == FN_MUL) || (r_func == FN_DIV);

    // finishing result, taken by the output register
    always_comb begin
        o_fin = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_modulus < 30'd2) begin
                    o_fin.fin = 1'b1;
                end
            end
            S_RED_FIN: begin
                o_fin.fin   = 1'b1;
                o_fin.value = w_red;
            end
            S_OP_GO: begin
                case (r_func)
                    FN_ADD: begin
                        o_fin.fin   = 1'b1;
                        o_fin.value = w_sum_r;
                    end
                    FN_SUB: begin
                        o_fin.fin   = 1'b1;
                        o_fin.value = w_diff;
                    end
                    FN_NEG: begin
                        o_fin.fin   = 1'b1;
                        o_fin.value = w_neg_r;
                    end
                    FN_POW: begin
                        o_fin.fin   = w_pow_le0;
                        o_fin.value = RES_W'(1);
                    end
                    default: o_fin.fin = 1'b0;
                endcase
            end
            S_FIN_ACC: begin
                o_fin.fin   = 1'b1;
                o_fin.value = r_acc;
            end
            S_EUC_FIN: begin
                o_fin.fin   = (r_func != FN_DIV);
                o_fin.value = w_inv;
            end
            S_PWR_SCAN: begin
                o_fin.fin   = (r_cnt == '0);
                o_fin.value = r_pr;
            end
            default: o_fin = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_func <= i_func;
                        r_a    <= i_operand_a;
                        r_b    <= i_operand_b;
                        r_neg  <= i_wide_value[WIDE_W-1];
                        r_w    <= (i_func == FN_REDUCE) ? w_mag : i_wide_value;
                        r_acc  <= '0;
                        r_mcnt <= MCNT_LAST;
                        r_cnt  <= WCNT_LAST;
                        if (i_modulus < 30'd2) begin
                            r_state <= S_IDLE;
                        end else if (i_func == FN_REDUCE) begin
                            r_state <= S_RED_W;
                        end else begin
                            r_state <= S_RED_A;
                        end
                    end
                end
                S_RED_A: begin
                    r_acc  <= i_step_rsp.res;
                    r_a    <= {r_a[RES_W-2:0], 1'b0};
                    r_mcnt <= r_mcnt - 5'd1;
                    if (r_mcnt == '0) begin
                        r_a     <= i_step_rsp.res;
                        r_acc   <= '0;
                        r_mcnt  <= MCNT_LAST;
                        r_state <= w_needs_b ? S_RED_B : S_OP_GO;
                    end
                end
                S_RED_B: begin
                    r_acc  <= i_step_rsp.res;
                    r_b    <= {r_b[RES_W-2:0], 1'b0};
                    r_mcnt <= r_mcnt - 5'd1;
                    if (r_mcnt == '0) begin
                        r_b     <= i_step_rsp.res;
                        r_state <= S_OP_GO;
                    end
                end
                S_RED_W: begin
                    r_acc <= i_step_rsp.res;
                    r_w   <= {r_w[WIDE_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_RED_FIN;
                    end
                end
                S_RED_FIN: r_state <= S_IDLE;
                S_OP_GO: begin
                    case (r_func)
                        FN_MUL: begin
                            r_mx    <= r_a;
                            r_my    <= r_b;
                            r_acc   <= '0;
                            r_mcnt  <= MCNT_LAST;
                            r_ret   <= S_FIN_ACC;
                            r_state <= S_MUL;
                        end
                        FN_DIV: begin
                            r_ea    <= r_b;
                            r_eb    <= i_modulus;
                            r_eu    <= 32'sd1;
                            r_ev    <= '0;
                            r_state <= S_EUC_CHK;
                        end
                        FN_INV: begin
                            r_ea    <= r_a;
                            r_eb    <= i_modulus;
                            r_eu    <= 32'sd1;
                            r_ev    <= '0;
                            r_state <= S_EUC_CHK;
                        end
                        FN_POW: begin
                            r_pr      <= RES_W'(1);
                            r_started <= 1'b0;
                            r_cnt     <= PCNT_INIT;
                            r_state   <= w_pow_le0 ? S_IDLE : S_PWR_SCAN;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_MUL: begin
                    r_acc  <= i_step_rsp.res;
                    r_my   <= {r_my[RES_W-2:0], 1'b0};
                    r_mcnt <= r_mcnt - 5'd1;
                    if (r_mcnt == '0) begin
                        r_state <= r_ret;
                    end
                end
                S_FIN_ACC: r_state <= S_IDLE;
                S_EUC_CHK: begin
                    if (r_eb == '0) begin
                        r_state <= S_EUC_FIN;
                    end else begin
                        r_acc   <= '0;
                        r_tv    <= '0;
                        r_mcnt  <= MCNT_LAST;
                        r_state <= S_EUC_DIV;
                    end
                end
                S_EUC_DIV: begin
                    r_acc  <= i_step_rsp.res;
                    r_ea   <= {r_ea[RES_W-2:0], 1'b0};
                    r_tv   <= n_tv;
                    r_mcnt <= r_mcnt - 5'd1;
                    if (r_mcnt == '0) begin
                        r_state <= S_EUC_UPD;
                    end
                end
                S_EUC_UPD: begin
                    r_ea    <= r_eb;
                    r_eb    <= r_acc;
                    r_eu    <= r_ev;
                    r_ev    <= r_eu - r_tv;
                    r_state <= S_EUC_CHK;
                end
                S_EUC_FIN: begin
                    if (r_func == FN_DIV) begin
                        r_mx    <= r_a;
                        r_my    <= w_inv;
                        r_acc   <= '0;
                        r_mcnt  <= MCNT_LAST;
                        r_ret   <= S_FIN_ACC;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PWR_SCAN: begin
                    if (r_cnt == '0) begin
                        r_state <= S_IDLE;
                    end else if (!r_started) begin
                        if (r_w[WIDE_W-1]) begin
                            r_pr      <= r_a;
                            r_started <= 1'b1;
                        end
                        r_w   <= {r_w[WIDE_W-2:0], 1'b0};
                        r_cnt <= r_cnt - 7'd1;
                    end else begin
                        r_mx    <= r_pr;
                        r_my    <= r_pr;
                        r_acc   <= '0;
                        r_mcnt  <= MCNT_LAST;
                        r_ret   <= S_PWR_SQ;
                        r_state <= S_MUL;
                    end
                end
                S_PWR_SQ: begin
                    r_pr <= r_acc;
                    if (r_w[WIDE_W-1]) begin
                        r_mx    <= r_acc;
                        r_my    <= r_a;
                        r_acc   <= '0;
                        r_mcnt  <= MCNT_LAST;
                        r_ret   <= S_PWR_ML;
                        r_state <= S_MUL;
                    end else begin
                        r_w     <= {r_w[WIDE_W-2:0], 1'b0};
                        r_cnt   <= r_cnt - 7'd1;
                        r_state <= S_PWR_SCAN;
                    end
                end
                S_PWR_ML: begin
                    r_pr    <= r_acc;
                    r_w     <= {r_w[WIDE_W-2:0], 1'b0};
                    r_cnt   <= r_cnt - 7'd1;
                    r_state <= S_PWR_SCAN;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MAU_ASSERT_IMP(a_div_nonzero, r_state == S_EUC_DIV, r_eb != '0)
    `MAU_ASSERT_IMP(a_acc_below_div, w_step_act, o_step_req.acc < o_step_req.div)
    `MAU_ASSERT_NXT(a_mul_return, (r_state == S_MUL) && (r_mcnt == '0), r_state == $past(r_ret))
    `MAU_ASSERT_IMP(a_fin_range, o_fin.fin && (i_modulus >= 30'd2), o_fin.value < i_modulus)

endmodule

>>> bench/modular_arithmetic_unit_test.sv
// self-checking bench for modular_arithmetic_unit: directed and random commands
// over several moduli, each result checked against a residue predictor
// depends on mau_pkg and the modular_arithmetic_unit rtl
`timescale 1ns / 1ps

module modular_arithmetic_unit_test;

    import mau_pkg::*;

    localparam int          CLK_PERIOD = 10;
    localparam int          RESET_CYCLES = 6;
    // slowest item is a full-width power; the timeout leaves room for 1600 of those
    // plus sender gaps, several times over
    localparam int unsigned TIMEOUT_NS = 400_000_000;
    // quiet cycles after the last residue, more than the longest item
    localparam int          LINGER_CYCLES = 5000;
    localparam int          REPORT_LIMIT = 10;

    localparam t_res               RES_MAX  = '1;
    localparam logic signed [63:0] WIDE_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] WIDE_MAX = {1'b0, {63{1'b1}}};

    // one command as seen on the ports, with the residue it must produce
    typedef struct {
        t_func              fn;
        t_res               a;
        t_res               b;
        logic signed [63:0] w;
        t_res               residue;
    } t_residue_entry;

    // modulus copy, residue prediction and in-order comparison
    class residue_ledger;
        t_res           modulus;
        t_residue_entry residue_q[$];
        int             mismatches;

        function new();
            modulus    = MOD_RESET;
            mismatches = 0;
        endfunction

        // operands are below 2**30, so the product fits in 64 bits
        function longint unsigned mul_mod(longint unsigned x, longint unsigned y,
                                          longint unsigned m);
            return (x * y) % m;
        endfunction

        // negative values are reduced by their unsigned magnitude
        function longint unsigned reduce_wide(longint v, longint unsigned m);
            longint unsigned mag;
            if (v >= 0) return $unsigned(v) % m;
            mag = 64'd0 - $unsigned(v);
            return (m - mag % m) % m;
        endfunction

        // extended euclid: u * x is congruent to gcd(x, m), zero maps to zero
        function longint unsigned euclid_inverse(longint unsigned x, longint unsigned m);
            longint g;
            longint r;
            longint u;
            longint v;
            longint q;
            longint tmp;
            g = x;
            r = m;
            u = 1;
            v = 0;
            while (r > 0) begin
                q   = g / r;
                tmp = g - q * r;
                g   = r;
                r   = tmp;
                tmp = u - q * v;
                u   = v;
                v   = tmp;
            end
            return reduce_wide(u, m);
        endfunction

        function t_res predict_residue(t_func fn, t_res a_in, t_res b_in,
                                       logic signed [63:0] w);
            longint unsigned m;
            longint unsigned a;
            longint unsigned b;
            longint unsigned r;
            longint unsigned base;
            longint unsigned n;
            m = modulus;
            if (m < 2) return '0;
            a = a_in % m;
            b = b_in % m;
            r = 0;
            case (fn)
                FN_REDUCE: r = reduce_wide(w, m);
                FN_ADD:    r = (a + b) % m;
                FN_SUB:    r = (a + m - b) % m;
                FN_MUL:    r = mul_mod(a, b, m);
                FN_DIV:    r = mul_mod(a, euclid_inverse(b, m), m);
                FN_NEG:    r = (m - a) % m;
                FN_INV:    r = euclid_inverse(a, m);
                FN_POW: begin
                    // exponents at or below zero give one
                    r = 1 % m;
                    if (w > 0) begin
                        base = a;
                        n    = w;
                        while (n != 0) begin
                            if (n[0]) r = mul_mod(r, base, m);
                            base = mul_mod(base, base, m);
                            n    = n >> 1;
                        end
                    end
                end
            endcase
            return t_res'(r);
        endfunction

        function void note_command(t_func fn, t_res a, t_res b, logic signed [63:0] w);
            t_residue_entry e;
            e.fn      = fn;
            e.a       = a;
            e.b       = b;
            e.w       = w;
            e.residue = predict_residue(fn, a, b, w);
            residue_q = {residue_q, e};
        endfunction

        function void check_residue(t_res got);
            t_residue_entry e;
            if (residue_q.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("residue %0d arrived with no command pending", got);
                mismatches++;
                return;
            end
            e = residue_q.pop_front();
            if (got !== e.residue) begin
                if (mismatches < REPORT_LIMIT)
                    $display("mod %0d %s a %0d b %0d w %0d: expected %0d, got %0d",
                             modulus, e.fn.name(), e.a, e.b, e.w, e.residue, got);
                mismatches++;
            end
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [2:0]                i_func = '0;
    logic [RES_W-1:0]          i_operand_a = '0;
    logic [RES_W-1:0]          i_operand_b = '0;
    logic signed [WIDE_W-1:0]  i_wide_value = '0;
    logic                      o_valid;
    logic [RES_W-1:0]          o_residue;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [RES_W-1:0]          i_cfg_data = '0;

    // random sender gaps, switched off for the last phase
    bit                        gaps_on = 1'b1;

    residue_ledger             ledger = new();

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    modular_arithmetic_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .i_wide_value (i_wide_value),
        .o_valid      (o_valid),
        .o_residue    (o_residue),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // monitor: every port is read at the edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // check first: a residue can never belong to a command taken at the same edge
            if (o_valid) ledger.check_residue(o_residue);
            if (start && !busy)
                ledger.note_command(t_func'(i_func), i_operand_a, i_operand_b, i_wide_value);
            // modulus transfer, only ever made while nothing is in flight
            if (i_cfg_valid && o_cfg_ready) ledger.modulus = i_cfg_data;
        end
    end

    // present one command and hold it until the transfer; start is left high
    // so the next command can follow at once without a dead cycle
    task automatic issue(input t_func fn, input t_res a, input t_res b,
                         input logic signed [63:0] w);
        start        <= 1'b1;
        i_func       <= fn;
        i_operand_a  <= a;
        i_operand_b  <= b;
        i_wide_value <= w;
        do @(posedge i_clk); while (busy);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every predicted residue has come back
    task automatic drain();
        start <= 1'b0;
        while (ledger.residue_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(input t_res value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // residue operands: edges of the range, values at and below the modulus,
    // and full 30-bit values that need reduction first
    function automatic t_res pick_operand(t_res m);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return RES_MAX;
            2:       return m;
            3:       return m - 1'b1;
            4, 5:    return (m < 2) ? t_res'($urandom) : t_res'($urandom % m);
            default: return t_res'($urandom);
        endcase
    endfunction

    // power exponents stay mostly short to keep the run length sane, with the
    // occasional full 64-bit value; reduce gets the whole signed range
    function automatic logic signed [63:0] pick_wide(t_func fn);
        logic [63:0] raw;
        int unsigned bits;
        raw = {$urandom, $urandom};
        if (fn == FN_POW) begin
            case ($urandom_range(0, 15))
                0:       return raw;
                1:       return 64'($urandom_range(0, 4)) - 64'd2;
                default: begin
                    bits = $urandom_range(1, 20);
                    return raw & ((64'd1 << bits) - 64'd1);
                end
            endcase
        end
        case ($urandom_range(0, 7))
            0:       return WIDE_MIN;
            1:       return WIDE_MAX;
            2:       return 64'($urandom_range(0, 4)) - 64'd2;
            default: return raw;
        endcase
    endfunction

    // hard stop in case the block never answers
    initial begin
        #TIMEOUT_NS;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_res  phase_modulus [9];
        int    phase_items [9];
        t_func fn;

        // prime reset value, both extremes, a small composite, random values,
        // the degenerate moduli one and zero, then the reset value written back
        phase_modulus = '{MOD_RESET, 30'd2, RES_MAX, 30'd12,
                          t_res'($urandom_range(3, 1000)),
                          t_res'($urandom_range(2, 30'h3FFFFFFF)),
                          30'd1, 30'd0, MOD_RESET};
        phase_items   = '{220, 200, 220, 180, 180, 220, 20, 20, 340};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed commands under the reset modulus
        issue(FN_REDUCE, '0, '0, 64'sd0);
        issue(FN_REDUCE, '0, '0, WIDE_MAX);
        issue(FN_REDUCE, '0, '0, WIDE_MIN);        // most negative value
        issue(FN_REDUCE, '0, '0, -64'sd1);
        issue(FN_ADD, RES_MAX, RES_MAX, '0);       // operands above the modulus
        issue(FN_SUB, '0, RES_MAX, '0);
        issue(FN_MUL, RES_MAX, RES_MAX, '0);
        issue(FN_DIV, 30'd5, '0, '0);              // division by zero
        issue(FN_DIV, 30'd6, 30'd3, '0);
        issue(FN_DIV, 30'd7, MOD_RESET, '0);       // divisor reduces to zero
        issue(FN_NEG, '0, '0, '0);
        issue(FN_NEG, RES_MAX, '0, '0);
        issue(FN_INV, '0, '0, '0);                 // inverse of zero
        issue(FN_INV, 30'd1, '0, '0);
        issue(FN_INV, RES_MAX, '0, '0);
        issue(FN_INV, MOD_RESET - 1'b1, '0, '0);
        issue(FN_POW, 30'd2, '0, 64'sd10);
        issue(FN_POW, 30'd5, '0, 64'sd0);          // exponent zero
        issue(FN_POW, 30'd5, '0, -64'sd1);         // negative exponent
        issue(FN_POW, 30'd3, '0, WIDE_MIN);
        issue(FN_POW, RES_MAX, '0, WIDE_MAX);      // longest square and multiply
        issue(FN_POW, '0, '0, 64'sd3);

        for (int p = 0; p < 9; p++) begin
            // the modulus changes only with the block idle
            if (p > 0) begin
                drain();
                write_modulus(phase_modulus[p]);
            end
            gaps_on = (p != 8);
            for (int i = 0; i < phase_items[p]; i++) begin
                fn = t_func'($urandom_range(0, 7));
                issue(fn, pick_operand(phase_modulus[p]), pick_operand(phase_modulus[p]),
                      pick_wide(fn));
                // hold off mid-phase until the block has answered everything
                if (p == 1 && i == phase_items[p] / 2) drain();
            end
        end

        drain();
        repeat (LINGER_CYCLES) @(posedge i_clk);
        if (ledger.residue_q.size() != 0) begin
            $display("%0d residues never arrived", ledger.residue_q.size());
            ledger.mismatches++;
        end

        if (ledger.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
